### design/abr_pkg.sv
// ----------------------------------------------------------------------------
// abr_pkg
// Shared widths, register codes and controller/datapath bundles for the
// adaptive bitrate level selector.
// ----------------------------------------------------------------------------
package abr_pkg;

  // Field widths of the item, result and configuration channels.
  localparam int unsigned KIND_W      = 1;
  localparam int unsigned LEVEL_IDX_W = 3;
  localparam int unsigned BITRATE_W   = 32;
  localparam int unsigned RATE_W      = 32;
  localparam int unsigned DUR_W       = 32;
  localparam int unsigned LCOUNT_W    = 4;
  localparam int unsigned FACTOR_W    = 20;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 20;

  // Reset values of the configuration registers.
  localparam logic [LCOUNT_W-1:0] LEVEL_COUNT_RST = LCOUNT_W'(1);
  localparam logic [FACTOR_W-1:0] UP_FACTOR_RST   = FACTOR_W'(25000);
  localparam logic [FACTOR_W-1:0] DOUBLE_UP_RST   = FACTOR_W'(50000);
  localparam logic [FACTOR_W-1:0] DOWN_FACTOR_RST = FACTOR_W'(12500);

  // Largest table the bundles below must address.
  localparam int unsigned LEVELS_MAX = 16;
  localparam int unsigned TAG_W      = $clog2(LEVELS_MAX);
  localparam int unsigned COUNT_W    = $clog2(LEVELS_MAX + 1);

  // Multiplier sequence: three factors, two partial products each.
  localparam int unsigned MUL_STEPS = 6;
  localparam int unsigned MSTEP_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_COUNT      = 2'd0,
    CFG_UP_FACTOR        = 2'd1,
    CFG_DOUBLE_UP_FACTOR = 2'd2,
    CFG_DOWN_FACTOR      = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    F_UP     = 2'd0,
    F_DOUBLE = 2'd1,
    F_DOWN   = 2'd2
  } fsel_e;

  typedef enum logic [1:0] {
    RD_CURRENT = 2'd0,
    RD_FIRST   = 2'd1,
    RD_WALK    = 2'd2
  } rd_sel_e;

  typedef enum logic {
    CH_ZERO  = 1'b0,
    CH_TABLE = 1'b1
  } chosen_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               capture;
    logic               table_write;
    logic               first_take;
    logic               accum;
    logic               rd_en;
    rd_sel_e            rd_sel;
    logic [TAG_W-1:0]   walk_idx;
    logic               cur_load;
    logic               mul_issue;
    logic [MSTEP_W-1:0] mul_step;
    logic               plan;
    logic               chosen_load;
    chosen_src_e        chosen_src;
    logic               emit;
  } abr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic               kind;
    logic               first;
    logic               known;
    logic               window_full;
    logic               move;
    logic [COUNT_W-1:0] count;
    logic               out_free;
  } abr_sts_t;

endpackage

### design/abr_in_if.sv
// ----------------------------------------------------------------------------
// abr_in_if
// Item channel: table writes and fragment reports.
// ----------------------------------------------------------------------------
interface abr_in_if import abr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [LEVEL_IDX_W-1:0] level_index;
  logic [BITRATE_W-1:0]   level_bitrate;
  logic                   measurement_known;
  logic [RATE_W-1:0]      measured_rate;
  logic [DUR_W-1:0]       fragment_duration;

  modport source (
    output valid, kind, level_index, level_bitrate, measurement_known,
           measured_rate, fragment_duration,
    input  ready
  );
  modport sink (
    input  valid, kind, level_index, level_bitrate, measurement_known,
           measured_rate, fragment_duration,
    output ready
  );
endinterface

### design/abr_out_if.sv
// ----------------------------------------------------------------------------
// abr_out_if
// Result channel: chosen bitrate, level and change flag.
// ----------------------------------------------------------------------------
interface abr_out_if import abr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [BITRATE_W-1:0]   chosen_bitrate;
  logic [LEVEL_IDX_W-1:0] chosen_level;
  logic                   bitrate_changed;

  modport source (
    output valid, chosen_bitrate, chosen_level, bitrate_changed,
    input  ready
  );
  modport sink (
    input  valid, chosen_bitrate, chosen_level, bitrate_changed,
    output ready
  );
endinterface

### design/abr_cfg_if.sv
// ----------------------------------------------------------------------------
// abr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface abr_cfg_if import abr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/adaptive_bitrate_level_select.sv
// ----------------------------------------------------------------------------
// adaptive_bitrate_level_select
// Picks a video quality level for each fragment report from a table of level
// bitrates. Items are taken one at a time. A report that closes a window
// runs the up and down tests, then walks the table when either holds and N,
// the saturated level count, is not zero. The window decision is set by one
// shared multiplier that forms six partial products in turn, and the step by
// a walk over the level table through its single RAM read port, one entry
// per cycle. A finished result waits in an output register while the next
// item is taken. Configuration writes are always ready and take effect at
// once.
// ----------------------------------------------------------------------------
module adaptive_bitrate_level_select import abr_pkg::*; #(
  parameter int unsigned LEVELS = 8,
  parameter int unsigned WINDOW = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  abr_in_if.sink    in_i,
  abr_out_if.source out_o,
  abr_cfg_if.sink   cfg_i
);

  localparam int unsigned LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  abr_cmd_t             cmd;
  abr_sts_t             sts;
  logic                 in_ready;
  logic                 ram_we, ram_re;
  logic [LVL_W-1:0]     ram_waddr, ram_raddr;
  logic [BITRATE_W-1:0] ram_wdata, ram_rdata;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // Sequencer.
  abr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  abr_datapath #(
    .LEVELS (LEVELS),
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_kind_i              (in_i.kind),
    .in_level_index_i       (in_i.level_index),
    .in_level_bitrate_i     (in_i.level_bitrate),
    .in_measurement_known_i (in_i.measurement_known),
    .in_measured_rate_i     (in_i.measured_rate),
    .in_fragment_duration_i (in_i.fragment_duration),
    .cfg_we_i               (cfg_i.valid),
    .cfg_index_i            (cfg_i.index),
    .cfg_data_i             (cfg_i.data),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .ram_we_o               (ram_we),
    .ram_waddr_o            (ram_waddr),
    .ram_wdata_o            (ram_wdata),
    .ram_re_o               (ram_re),
    .ram_raddr_o            (ram_raddr),
    .ram_rdata_i            (ram_rdata),
    .out_valid_o            (out_o.valid),
    .out_ready_i            (out_o.ready),
    .out_chosen_bitrate_o   (out_o.chosen_bitrate),
    .out_chosen_level_o     (out_o.chosen_level),
    .out_bitrate_changed_o  (out_o.bitrate_changed)
  );

  // Level table.
  abr_ram #(
    .WIDTH (BITRATE_W),
    .DEPTH (LEVELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  // Only one item is in flight: ready drops after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item accepted while another is in flight");

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over an untaken one");

  // A loaded result is presented in the next cycle.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_o.valid)
    else $error("loaded result not presented");

  // The walk never runs past the table.
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= COUNT_W'(LEVELS))
    else $error("level count not saturated");
`endif

endmodule

### design/abr_ram.sv
// ----------------------------------------------------------------------------
// abr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module abr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/abr_ctrl.sv
// ----------------------------------------------------------------------------
// abr_ctrl
// Sequencer for the level selector: decodes each item, runs the multiplier
// sequence and the table walk, and hands the result to the output register.
// ----------------------------------------------------------------------------
module abr_ctrl import abr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  abr_sts_t sts_i,
  output abr_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_PLAN,
    ST_WALK,
    ST_FINAL,
    ST_FETCH,
    ST_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [MSTEP_W-1:0] mstep_q, mstep_d;
  logic [COUNT_W-1:0] walk_cnt_q, walk_cnt_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    mstep_d    = mstep_q;
    walk_cnt_d = walk_cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel     = RD_CURRENT;
    cmd_o.chosen_src = CH_ZERO;
    cmd_o.mul_step   = mstep_q;
    cmd_o.walk_idx   = TAG_W'(walk_cnt_q);

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (sts_i.kind) begin
          cmd_o.table_write = 1'b1;
          state_d           = ST_EMIT;
        end else if (sts_i.first) begin
          cmd_o.first_take = 1'b1;
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_sel     = RD_FIRST;
          state_d          = ST_FETCH;
        end else if (!sts_i.known) begin
          cmd_o.chosen_load = 1'b1;
          cmd_o.chosen_src  = CH_ZERO;
          state_d           = ST_EMIT;
        end else begin
          cmd_o.accum = 1'b1;
          if (sts_i.window_full) begin
            mstep_d = '0;
            state_d = ST_MUL;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_CURRENT;
            state_d      = ST_FETCH;
          end
        end
      end

      // Six partial products, then a final step that folds the last one.
      ST_MUL: begin
        cmd_o.mul_issue = (mstep_q < MSTEP_W'(MUL_STEPS));
        cmd_o.rd_en     = (mstep_q == '0);
        cmd_o.rd_sel    = RD_CURRENT;
        cmd_o.cur_load  = (mstep_q == MSTEP_W'(1));
        if (mstep_q == MSTEP_W'(MUL_STEPS)) begin
          state_d = ST_PLAN;
        end else begin
          mstep_d = mstep_q + MSTEP_W'(1);
        end
      end

      ST_PLAN: begin
        cmd_o.plan = 1'b1;
        walk_cnt_d = '0;
        if (sts_i.move && (sts_i.count != '0)) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_FINAL;
        end
      end

      // One table read per cycle; the last entry is judged in the cycle after its read.
      ST_WALK: begin
        if (walk_cnt_q < sts_i.count) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_WALK;
          walk_cnt_d   = walk_cnt_q + COUNT_W'(1);
        end else begin
          state_d = ST_FINAL;
        end
      end

      ST_FINAL: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CURRENT;
        state_d      = ST_FETCH;
      end

      ST_FETCH: begin
        cmd_o.chosen_load = 1'b1;
        cmd_o.chosen_src  = CH_TABLE;
        state_d           = ST_EMIT;
      end

      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and sequence counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mstep_q    <= '0;
      walk_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      mstep_q    <= mstep_d;
      walk_cnt_q <= walk_cnt_d;
    end
  end

endmodule

### design/abr_datapath.sv
// ----------------------------------------------------------------------------
// abr_datapath
// Item registers, configuration registers, window sums, the shared
// multiplier with its comparisons, level stepping and the result register.
// ----------------------------------------------------------------------------
module abr_datapath import abr_pkg::*; #(
  parameter int unsigned LEVELS = 8,
  parameter int unsigned WINDOW = 3,
  localparam int unsigned LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Item fields
  input  logic [KIND_W-1:0]      in_kind_i,
  input  logic [LEVEL_IDX_W-1:0] in_level_index_i,
  input  logic [BITRATE_W-1:0]   in_level_bitrate_i,
  input  logic                   in_measurement_known_i,
  input  logic [RATE_W-1:0]      in_measured_rate_i,
  input  logic [DUR_W-1:0]       in_fragment_duration_i,
  // Configuration writes
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Controller
  input  abr_cmd_t               cmd_i,
  output abr_sts_t               sts_o,
  // Level table RAM
  output logic                   ram_we_o,
  output logic [LVL_W-1:0]       ram_waddr_o,
  output logic [BITRATE_W-1:0]   ram_wdata_o,
  output logic                   ram_re_o,
  output logic [LVL_W-1:0]       ram_raddr_o,
  input  logic [BITRATE_W-1:0]   ram_rdata_i,
  // Result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [BITRATE_W-1:0]   out_chosen_bitrate_o,
  output logic [LEVEL_IDX_W-1:0] out_chosen_level_o,
  output logic                   out_bitrate_changed_o
);

  localparam int unsigned SUM_W  = RATE_W + $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned HALF_W = (SUM_W + 1) / 2;
  localparam int unsigned PP_W   = HALF_W + FACTOR_W;
  localparam int unsigned PROD_W = SUM_W + FACTOR_W;

  // Captured item.
  logic [KIND_W-1:0]      kind_q;
  logic [LEVEL_IDX_W-1:0] idx_q;
  logic [BITRATE_W-1:0]   wbr_q;
  logic                   known_q;
  logic [RATE_W-1:0]      rate_q;
  logic [DUR_W-1:0]       dur_q;

  // Configuration.
  logic [LCOUNT_W-1:0] level_count_q;
  logic [FACTOR_W-1:0] up_factor_q, double_up_q, down_factor_q;

  // Selector state.
  logic [LVL_W-1:0]     cur_level_q;
  logic                 first_q;
  logic [FILL_W-1:0]    fill_q;
  logic [SUM_W-1:0]     rate_sum_q, dur_sum_q;
  logic [BITRATE_W-1:0] last_q;
  logic                 last_valid_q;

  // Decision working registers.
  logic [BITRATE_W-1:0] cur_rate_q;
  logic [PP_W-1:0]      pp_q, acc_q;
  logic [MSTEP_W-1:0]   pp_tag_q;
  logic                 pp_valid_q;
  logic                 up_ok_q, double_ok_q, down_ok_q;
  logic [1:0]           need_q;
  logic                 down_mode_q, found_q;
  logic                 walk_pend_q;
  logic [LVL_W-1:0]     walk_tag_q;
  logic [BITRATE_W-1:0] chosen_q;

  // Result register.
  logic                   out_valid_q;
  logic [BITRATE_W-1:0]   out_bitrate_q;
  logic [LEVEL_IDX_W-1:0] out_level_q;
  logic                   out_changed_q;

  logic [FILL_W:0]      fill_inc;
  logic                 window_full;
  logic [COUNT_W-1:0]   count_sat;
  logic [HALF_W-1:0]    mul_a;
  logic [FACTOR_W-1:0]  mul_b;
  logic [PROD_W-1:0]    prod;
  logic                 walk_up_hit, walk_down_hit;

  // Capture the accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= in_kind_i;
      idx_q   <= in_level_index_i;
      wbr_q   <= in_level_bitrate_i;
      known_q <= in_measurement_known_i;
      rate_q  <= in_measured_rate_i;
      dur_q   <= in_fragment_duration_i;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= LEVEL_COUNT_RST;
      up_factor_q   <= UP_FACTOR_RST;
      double_up_q   <= DOUBLE_UP_RST;
      down_factor_q <= DOWN_FACTOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_LEVEL_COUNT:      level_count_q <= cfg_data_i[LCOUNT_W-1:0];
        CFG_UP_FACTOR:        up_factor_q   <= cfg_data_i[FACTOR_W-1:0];
        CFG_DOUBLE_UP_FACTOR: double_up_q   <= cfg_data_i[FACTOR_W-1:0];
        CFG_DOWN_FACTOR:      down_factor_q <= cfg_data_i[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // The valid count saturates at the table depth.
  assign count_sat = (COUNT_W'(level_count_q) > COUNT_W'(LEVELS)) ?
                     COUNT_W'(LEVELS) : COUNT_W'(level_count_q);

  assign fill_inc    = {1'b0, fill_q} + (FILL_W + 1)'(1);
  assign window_full = (fill_inc >= (FILL_W + 1)'(WINDOW));

  // Table RAM access.
  assign ram_we_o    = cmd_i.table_write && (COUNT_W'(idx_q) < COUNT_W'(LEVELS));
  assign ram_waddr_o = LVL_W'(idx_q);
  assign ram_wdata_o = wbr_q;
  assign ram_re_o    = cmd_i.rd_en;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_CURRENT: ram_raddr_o = cur_level_q;
      RD_FIRST:   ram_raddr_o = '0;
      RD_WALK:    ram_raddr_o = LVL_W'(cmd_i.walk_idx);
      default:    ram_raddr_o = cur_level_q;
    endcase
  end

  // Shared multiplier operands: one half of the rate sum times one factor.
  always_comb begin
    mul_a = cmd_i.mul_step[0] ? HALF_W'(rate_sum_q[SUM_W-1:HALF_W]) :
                                rate_sum_q[HALF_W-1:0];
    case (fsel_e'(cmd_i.mul_step[2:1]))
      F_UP:     mul_b = up_factor_q;
      F_DOUBLE: mul_b = double_up_q;
      F_DOWN:   mul_b = down_factor_q;
      default:  mul_b = down_factor_q;
    endcase
  end

  // Full product from the high partial product and the held low one.
  assign prod = (PROD_W'(pp_q) << HALF_W) + PROD_W'(acc_q);

  // Table walk hits for the entry read in the previous cycle.
  assign walk_up_hit   = walk_pend_q && (need_q != 2'd0) && (ram_rdata_i > cur_rate_q);
  assign walk_down_hit = walk_pend_q && down_mode_q && !found_q &&
                         (ram_rdata_i < cur_rate_q);

  // Payload registers of the decision.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_issue) begin
      pp_q     <= PP_W'(mul_a) * PP_W'(mul_b);
      pp_tag_q <= cmd_i.mul_step;
    end
    if (pp_valid_q && !pp_tag_q[0]) begin
      acc_q <= pp_q;
    end
    if (cmd_i.cur_load) begin
      cur_rate_q <= ram_rdata_i;
    end
    if (cmd_i.rd_en) begin
      walk_tag_q <= LVL_W'(cmd_i.walk_idx);
    end
    if (cmd_i.chosen_load) begin
      chosen_q <= (cmd_i.chosen_src == CH_TABLE) ? ram_rdata_i : '0;
    end
  end

  // Comparison flags, filled as each full product completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_valid_q  <= 1'b0;
      up_ok_q     <= 1'b0;
      double_ok_q <= 1'b0;
      down_ok_q   <= 1'b0;
    end else begin
      pp_valid_q <= cmd_i.mul_issue;
      if (pp_valid_q && pp_tag_q[0]) begin
        case (fsel_e'(pp_tag_q[2:1]))
          F_UP:     up_ok_q     <= (prod <= PROD_W'(dur_sum_q));
          F_DOUBLE: double_ok_q <= (prod <= PROD_W'(dur_sum_q));
          F_DOWN:   down_ok_q   <= (prod >= PROD_W'(dur_sum_q));
          default: ;
        endcase
      end
    end
  end

  // Selector state: level, window and walk control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_level_q <= '0;
      first_q     <= 1'b1;
      fill_q      <= '0;
      rate_sum_q  <= '0;
      dur_sum_q   <= '0;
      need_q      <= 2'd0;
      down_mode_q <= 1'b0;
      found_q     <= 1'b0;
      walk_pend_q <= 1'b0;
    end else begin
      walk_pend_q <= cmd_i.rd_en && (cmd_i.rd_sel == RD_WALK);

      if (cmd_i.first_take) begin
        cur_level_q <= '0;
        first_q     <= 1'b0;
      end

      if (cmd_i.accum) begin
        rate_sum_q <= rate_sum_q + SUM_W'(rate_q);
        dur_sum_q  <= dur_sum_q + SUM_W'(dur_q);
        fill_q     <= window_full ? '0 : FILL_W'(fill_inc);
      end

      // Window closes: fix the walk mode and restart the sums.
      if (cmd_i.plan) begin
        need_q      <= up_ok_q ? (double_ok_q ? 2'd2 : 2'd1) : 2'd0;
        down_mode_q <= !up_ok_q && down_ok_q;
        found_q     <= 1'b0;
        rate_sum_q  <= '0;
        dur_sum_q   <= '0;
      end

      if (walk_up_hit) begin
        need_q      <= need_q - 2'd1;
        cur_level_q <= walk_tag_q;
      end else if (walk_down_hit) begin
        found_q     <= 1'b1;
        cur_level_q <= walk_tag_q;
      end
    end
  end

  // Result register and last reported bitrate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      last_q       <= '0;
      last_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (kind_q == KIND_W'(0)) begin
          last_q       <= chosen_q;
          last_valid_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_bitrate_q <= (kind_q == KIND_W'(0)) ? chosen_q : '0;
      out_level_q   <= LEVEL_IDX_W'(cur_level_q);
      out_changed_q <= (kind_q == KIND_W'(0)) && (!last_valid_q || (last_q != chosen_q));
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_chosen_bitrate_o  = out_bitrate_q;
  assign out_chosen_level_o    = out_level_q;
  assign out_bitrate_changed_o = out_changed_q;

  // Status to the controller.
  always_comb begin
    sts_o             = '0;
    sts_o.kind        = (kind_q != KIND_W'(0));
    sts_o.first       = first_q;
    sts_o.known       = known_q;
    sts_o.window_full = window_full;
    sts_o.move        = up_ok_q || down_ok_q;
    sts_o.count       = count_sat;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

### tb/adaptive_bitrate_level_select_tb.sv
// ----------------------------------------------------------------------------
// adaptive_bitrate_level_select_tb
// Self-checking testbench for the adaptive bitrate level selector. A
// behavioural copy of the level selection runs beside the block. Every
// accepted item pushes the predicted choice into a queue. Every result that
// the block hands over is compared field by field with the oldest entry.
// Directed items cover the first report, unknown measurements, a double
// step up, a step down, holding the level and the field extremes.
// Random windows follow under a sweep of register settings, with random
// stalls on both channels and one stretch that runs back to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_bitrate_level_select_tb;
  import abr_pkg::*;

  localparam int unsigned TABLE_DEPTH = 8;
  localparam int unsigned WINDOW_LEN  = 3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYC  = 24;
  localparam int unsigned PHASE_ITEMS = 180;

  localparam logic [KIND_W-1:0] KIND_REPORT      = 1'b0;
  localparam logic [KIND_W-1:0] KIND_TABLE_WRITE = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [LEVEL_IDX_W-1:0] level_index;
    logic [BITRATE_W-1:0]   level_bitrate;
    logic                   measurement_known;
    logic [RATE_W-1:0]      measured_rate;
    logic [DUR_W-1:0]       fragment_duration;
  } abr_item_t;

  typedef struct packed {
    logic [BITRATE_W-1:0]   bitrate;
    logic [LEVEL_IDX_W-1:0] level;
    logic                   changed;
  } choice_t;

  logic clk_i;
  logic rst_ni;

  abr_in_if  in_if ();
  abr_out_if out_if ();
  abr_cfg_if cfg_if ();

  adaptive_bitrate_level_select dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of the selector state and its registers.
  logic [BITRATE_W-1:0]   level_table [TABLE_DEPTH];
  logic [LEVEL_IDX_W-1:0] cur_level;
  logic                   first_pending;
  int unsigned            window_fill;
  logic [33:0]            rate_sum;
  logic [33:0]            dur_sum;
  logic [BITRATE_W-1:0]   last_bitrate;
  logic                   last_valid;
  logic [LCOUNT_W-1:0]    lvl_count;
  logic [FACTOR_W-1:0]    up_f;
  logic [FACTOR_W-1:0]    dup_f;
  logic [FACTOR_W-1:0]    down_f;

  choice_t     expected_choices [$];
  choice_t     oldest_choice;
  int unsigned mismatches;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned win_ratio;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Works out the choice that one accepted item causes and updates the state.
  function automatic choice_t predict_choice(input abr_item_t it);
    choice_t              res;
    logic [BITRATE_W-1:0] picked;
    logic [BITRATE_W-1:0] cur_rate;
    int unsigned          n;
    int unsigned          need;
    logic                 found;
    if (it.kind == KIND_TABLE_WRITE) begin
      level_table[it.level_index] = it.level_bitrate;
      res.bitrate = '0;
      res.level   = cur_level;
      res.changed = 1'b0;
      return res;
    end
    if (first_pending) begin
      cur_level     = '0;
      first_pending = 1'b0;
      picked        = level_table[0];
    end else if (!it.measurement_known) begin
      picked = '0;
    end else begin
      rate_sum    = rate_sum + 34'(it.measured_rate);
      dur_sum     = dur_sum + 34'(it.fragment_duration);
      window_fill = window_fill + 1;
      if (window_fill >= WINDOW_LEN) begin
        // Window closed: compare the scaled rate sum with the duration sum.
        cur_rate = level_table[cur_level];
        n        = (lvl_count > 4'd8) ? TABLE_DEPTH : int'(lvl_count);
        if (64'(rate_sum) * 64'(up_f) <= 64'(dur_sum)) begin
          need = (64'(rate_sum) * 64'(dup_f) <= 64'(dur_sum)) ? 2 : 1;
          for (int i = 0; i < n; i++) begin
            if (need > 0 && level_table[i] > cur_rate) begin
              need      = need - 1;
              cur_level = LEVEL_IDX_W'(i);
            end
          end
        end else if (64'(rate_sum) * 64'(down_f) >= 64'(dur_sum)) begin
          found = 1'b0;
          for (int i = 0; i < n; i++) begin
            if (!found && level_table[i] < cur_rate) begin
              found     = 1'b1;
              cur_level = LEVEL_IDX_W'(i);
            end
          end
        end
        window_fill = 0;
        rate_sum    = '0;
        dur_sum     = '0;
      end
      picked = level_table[cur_level];
    end
    res.bitrate  = picked;
    res.level    = cur_level;
    res.changed  = !last_valid || (last_bitrate != picked);
    last_bitrate = picked;
    last_valid   = 1'b1;
    return res;
  endfunction

  // A fragment report; the table fields carry junk that must be ignored.
  function automatic abr_item_t make_report(input logic known, input logic [RATE_W-1:0] rate,
                                            input logic [DUR_W-1:0] dur);
    abr_item_t it;
    it.kind              = KIND_REPORT;
    it.level_index       = LEVEL_IDX_W'($urandom);
    it.level_bitrate     = $urandom;
    it.measurement_known = known;
    it.measured_rate     = rate;
    it.fragment_duration = dur;
    return it;
  endfunction

  // A table write; the report fields carry junk that must be ignored.
  function automatic abr_item_t make_write(input logic [LEVEL_IDX_W-1:0] idx,
                                           input logic [BITRATE_W-1:0] br);
    abr_item_t it;
    it.kind              = KIND_TABLE_WRITE;
    it.level_index       = idx;
    it.level_bitrate     = br;
    it.measurement_known = 1'($urandom);
    it.measured_rate     = $urandom;
    it.fragment_duration = $urandom;
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offers one item, idling at random first, and predicts it once accepted.
  // Valid stays high on return so that a following item can go back to back.
  task automatic send_item(input abr_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.kind              <= it.kind;
    in_if.level_index       <= it.level_index;
    in_if.level_bitrate     <= it.level_bitrate;
    in_if.measurement_known <= it.measurement_known;
    in_if.measured_rate     <= it.measured_rate;
    in_if.fragment_duration <= it.fragment_duration;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_choices.push_back(predict_choice(it));
  endtask

  // Stops offering items and waits until every expected choice has arrived.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_choices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_LEVEL_COUNT:      lvl_count = val[LCOUNT_W-1:0];
      CFG_UP_FACTOR:        up_f      = val[FACTOR_W-1:0];
      CFG_DOUBLE_UP_FACTOR: dup_f     = val[FACTOR_W-1:0];
      CFG_DOWN_FACTOR:      down_f    = val[FACTOR_W-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drains the block, then writes all four registers.
  task automatic apply_setting(input logic [LCOUNT_W-1:0] cnt, input logic [FACTOR_W-1:0] upv,
                               input logic [FACTOR_W-1:0] dupv,
                               input logic [FACTOR_W-1:0] downv);
    wait_idle();
    write_reg(CFG_LEVEL_COUNT, CFG_DATA_W'(cnt));
    write_reg(CFG_UP_FACTOR, CFG_DATA_W'(upv));
    write_reg(CFG_DOUBLE_UP_FACTOR, CFG_DATA_W'(dupv));
    write_reg(CFG_DOWN_FACTOR, CFG_DATA_W'(downv));
  endtask

  // Mostly whole windows whose duration to rate ratio often sits near one of the
  // thresholds, mixed with table writes, unknown measurements and noise.
  task automatic run_mixed_items(input int unsigned n);
    int unsigned          sel;
    int                   r;
    logic [31:0]          max_rate;
    logic [RATE_W-1:0]    rate;
    logic [63:0]          dur;
    logic [BITRATE_W-1:0] br;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        case ($urandom_range(7))
          0:       br = '0;
          1:       br = '1;
          2, 3:    br = level_table[$urandom_range(TABLE_DEPTH - 1)];
          default: br = $urandom;
        endcase
        send_item(make_write(LEVEL_IDX_W'($urandom_range(TABLE_DEPTH - 1)), br));
      end else if (sel < 18) begin
        send_item(make_report(1'b0, $urandom, $urandom));
      end else if (sel < 25) begin
        rate = ($urandom_range(3) == 0) ? '1 : $urandom;
        dur  = ($urandom_range(3) == 0) ? '1 : $urandom;
        send_item(make_report(1'b1, rate, dur[DUR_W-1:0]));
      end else begin
        // A fresh window picks a ratio near a decision point, their midpoint or a random value.
        if (window_fill == 0) begin
          case ($urandom_range(4))
            0:       r = int'(up_f);
            1:       r = int'(dup_f);
            2:       r = int'(down_f);
            3:       r = (int'(up_f) + int'(down_f)) / 2;
            default: r = int'($urandom_range(2097150));
          endcase
          r = r + int'($urandom_range(4)) - 2;
          win_ratio = (r < 0) ? 0 : r;
        end
        max_rate = (win_ratio == 0) ? 32'hFFFF_FFFF : 32'hFFFF_FFFF / win_ratio;
        if ($urandom_range(9) < 3) begin
          rate = $urandom_range((max_rate < 16) ? max_rate : 16);
        end else begin
          rate = $urandom_range(max_rate);
        end
        dur = 64'(rate) * 64'(win_ratio);
        send_item(make_report(1'b1, rate, dur[DUR_W-1:0]));
      end
    end
  endtask

  // All eight entries, extremes among them, so that no report reads an
  // entry that was never written.
  task automatic test_table_fill();
    logic [BITRATE_W-1:0] init_rates [TABLE_DEPTH];
    init_rates = '{32'd1_000_000, 32'd0, 32'd2_000_000, 32'hFFFF_FFFF,
                   32'd4_000_000, 32'd500_000, 32'd8_000_000, 32'd3_000_000};
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_item(make_write(LEVEL_IDX_W'(i), init_rates[i]));
    end
  endtask

  // The first report takes entry zero whatever its measurement says.
  task automatic test_first_report();
    apply_setting(4'd8, UP_FACTOR_RST, DOUBLE_UP_RST, DOWN_FACTOR_RST);
    send_item(make_report(1'b0, '1, '1));
  endtask

  // An unknown measurement reports zero; the second one is no change.
  task automatic test_unknown_measurement();
    send_item(make_report(1'b0, 32'd7, 32'd9));
    send_item(make_report(1'b0, '0, '0));
  endtask

  task automatic test_double_step_up();
    repeat (WINDOW_LEN) send_item(make_report(1'b1, 32'd1, 32'd60000));
  endtask

  task automatic test_step_down();
    repeat (WINDOW_LEN) send_item(make_report(1'b1, 32'd1000, 32'd1000));
  endtask

  task automatic test_hold_level();
    repeat (WINDOW_LEN) send_item(make_report(1'b1, 32'd1, 32'd20000));
  endtask

  task automatic test_field_extremes();
    send_item(make_report(1'b1, '1, '1));
    send_item(make_report(1'b1, '0, '1));
    send_item(make_report(1'b1, '1, '0));
  endtask

  task automatic test_reset_setting();
    apply_setting(4'd8, UP_FACTOR_RST, DOUBLE_UP_RST, DOWN_FACTOR_RST);
    run_mixed_items(PHASE_ITEMS);
  endtask

  task automatic test_minimum_setting();
    apply_setting(4'd1, 20'd1, 20'd1, 20'd1);
    run_mixed_items(PHASE_ITEMS);
  endtask

  task automatic test_maximum_setting();
    apply_setting(4'd8, 20'd1_000_000, 20'd1_000_000, 20'd1_000_000);
    run_mixed_items(PHASE_ITEMS);
  endtask

  // A count of zero never moves the level; fifteen saturates at the depth.
  task automatic test_count_limits();
    apply_setting(4'd0, 20'd40, 20'd80, 20'd20);
    run_mixed_items(PHASE_ITEMS / 2);
    apply_setting(4'd15, 20'd0, 20'hFFFFF, 20'd0);
    run_mixed_items(PHASE_ITEMS);
  endtask

  task automatic test_extreme_factors();
    apply_setting(4'd8, 20'hFFFFF, 20'd0, 20'hFFFFF);
    run_mixed_items(PHASE_ITEMS);
  endtask

  // Random ordered factors, run either with the usual stalls or with none at all.
  task automatic test_random_settings(input logic no_stalls);
    logic [FACTOR_W-1:0] f [3];
    logic [FACTOR_W-1:0] t;
    for (int i = 0; i < 3; i++) f[i] = FACTOR_W'($urandom_range(1_000_000, 1));
    if (f[0] > f[1]) begin t = f[0]; f[0] = f[1]; f[1] = t; end
    if (f[1] > f[2]) begin t = f[1]; f[1] = f[2]; f[2] = t; end
    if (f[0] > f[1]) begin t = f[0]; f[0] = f[1]; f[1] = t; end
    apply_setting(LCOUNT_W'($urandom_range(8, 1)), f[1], f[2], f[0]);
    if (no_stalls) begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    run_mixed_items(PHASE_ITEMS);
    src_idle_pct = 26;
    snk_idle_pct = 26;
  endtask

  // Result sink: random back-pressure.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Compare each handed-over result with the oldest expected choice.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_choices.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        oldest_choice = expected_choices.pop_front();
        if (out_if.chosen_bitrate !== oldest_choice.bitrate) begin
          report_mismatch($sformatf("chosen_bitrate got %0h want %0h",
                                    out_if.chosen_bitrate, oldest_choice.bitrate));
        end
        if (out_if.chosen_level !== oldest_choice.level) begin
          report_mismatch($sformatf("chosen_level got %0d want %0d",
                                    out_if.chosen_level, oldest_choice.level));
        end
        if (out_if.bitrate_changed !== oldest_choice.changed) begin
          report_mismatch($sformatf("bitrate_changed got %0b want %0b",
                                    out_if.bitrate_changed, oldest_choice.changed));
        end
      end
    end
  end

  // Watchdog: ends the run when no channel has moved for too long.
  initial begin : watchdog
    int unsigned stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $display("[%0t] timeout with %0d results outstanding", $realtime,
             expected_choices.size());
    $display("adaptive_bitrate_level_select test failed");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_ni                  = 1'b0;
    in_if.valid             = 1'b0;
    in_if.kind              = KIND_REPORT;
    in_if.level_index       = '0;
    in_if.level_bitrate     = '0;
    in_if.measurement_known = 1'b0;
    in_if.measured_rate     = '0;
    in_if.fragment_duration = '0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = CFG_LEVEL_COUNT;
    cfg_if.data             = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) level_table[i] = '0;
    cur_level     = '0;
    first_pending = 1'b1;
    window_fill   = 0;
    rate_sum      = '0;
    dur_sum       = '0;
    last_bitrate  = '0;
    last_valid    = 1'b0;
    lvl_count     = LEVEL_COUNT_RST;
    up_f          = UP_FACTOR_RST;
    dup_f         = DOUBLE_UP_RST;
    down_f        = DOWN_FACTOR_RST;
    mismatches    = 0;
    win_ratio     = 0;
    src_idle_pct  = 26;
    snk_idle_pct  = 26;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_fill();
    test_first_report();
    test_unknown_measurement();
    test_double_step_up();
    test_step_down();
    test_hold_level();
    test_field_extremes();
    test_reset_setting();
    test_minimum_setting();
    test_maximum_setting();
    test_random_settings(1'b1);
    test_count_limits();
    test_extreme_factors();
    test_random_settings(1'b0);
    test_random_settings(1'b0);
    wait_idle();

    if (mismatches == 0) begin
      $display("adaptive_bitrate_level_select test passed");
    end else begin
      $display("adaptive_bitrate_level_select test failed");
    end
    $finish;
  end

endmodule
